[hdl/aah_pkg.sv]
package aah_pkg;

    // Default histogram size
    localparam int NUM_BINS_DEF = 32;

    // CORDIC datapath
    localparam int CORDIC_ITERS = 24;
    localparam int XW = 28;                // x/y lanes, operands pre-scaled by 2^8
    localparam int ZW = 34;                // angle accumulator, one turn is 2^32
    localparam int UW = 33;                // angle plus half turn, 0 .. 2^32

    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] FULL_TURN    = ZW'(64'sd4294967296);

    // Configuration register indexes
    localparam logic [1:0] REG_MIN_RADIUS_SQ = 2'd0;
    localparam logic [1:0] REG_MAX_RADIUS_SQ = 2'd1;

    typedef struct packed {
        logic              req_type;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic              is_self;
        logic [4:0]        read_bin;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic [4:0]  bin_index;
        logic [31:0] bin_count;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_t;

    // Per-item control travelling down the pipeline
    typedef struct packed {
        logic       valid;
        logic       is_read;
        logic       is_hit;
        logic [4:0] read_bin;
    } ctl_t;

    // CORDIC starting vector
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 fixed;
    } vec_t;

    // Histogram stage status toward the front end
    typedef struct packed {
        logic advance;
        logic clearing;
    } hist_stat_t;

    // Arctangent of 2^-i in turns scaled by 2^32
    function automatic logic [29:0] atan_turn(input int unsigned idx);
        logic [29:0] r;
        case (idx)
            0:       r = 30'd536870912;
            1:       r = 30'd316933406;
            2:       r = 30'd167458907;
            3:       r = 30'd85004756;
            4:       r = 30'd42667331;
            5:       r = 30'd21354465;
            6:       r = 30'd10679838;
            7:       r = 30'd5340245;
            8:       r = 30'd2670163;
            9:       r = 30'd1335087;
            10:      r = 30'd667544;
            11:      r = 30'd333772;
            12:      r = 30'd166886;
            13:      r = 30'd83443;
            14:      r = 30'd41722;
            15:      r = 30'd20861;
            16:      r = 30'd10430;
            17:      r = 30'd5215;
            18:      r = 30'd2608;
            19:      r = 30'd1304;
            20:      r = 30'd652;
            21:      r = 30'd326;
            22:      r = 30'd163;
            23:      r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/aah_stream_if.sv]
interface aah_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

[hdl/aah_front.sv]
module aah_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            accept,
    input  aah_pkg::req_t   req_in,
    input  logic [31:0]     min_radius_sq,
    input  logic [31:0]     max_radius_sq,
    output aah_pkg::ctl_t   ctl,
    output aah_pkg::vec_t   vec
);
    import aah_pkg::*;

    logic        f1_valid_reg;
    req_t        f1_req_reg;
    logic        f2_valid_reg;
    req_t        f2_req_reg;
    logic [31:0] sq_x_reg;
    logic [31:0] sq_y_reg;
    vec_t        f2_vec_reg;
    ctl_t        f3_ctl_reg;
    vec_t        f3_vec_reg;

    logic signed [31:0]   sq_x;
    logic signed [31:0]   sq_y;
    logic signed [XW-1:0] dx_ext;
    logic signed [XW-1:0] dy_ext;
    vec_t                 vec_next;
    logic [31:0]          d2;
    logic                 hit;

    // Square the components
    assign sq_x = 32'(f1_req_reg.dx) * 32'(f1_req_reg.dx);
    assign sq_y = 32'(f1_req_reg.dy) * 32'(f1_req_reg.dy);

    // Fold into the right half plane, pin axis points to exact angles
    always_comb
    begin
        dx_ext         = XW'(f1_req_reg.dx);
        dy_ext         = XW'(f1_req_reg.dy);
        vec_next.fixed = (f1_req_reg.dx == 16'sd0) || (f1_req_reg.dy == 16'sd0);
        vec_next.x     = dx_ext <<< 8;
        vec_next.y     = dy_ext <<< 8;
        vec_next.z     = '0;
        if (f1_req_reg.dy == 16'sd0)
        begin
            vec_next.z = (f1_req_reg.dx < 16'sd0) ? HALF_TURN : '0;
        end
        else if (f1_req_reg.dx == 16'sd0)
        begin
            vec_next.z = (f1_req_reg.dy > 16'sd0) ? QUARTER_TURN : -QUARTER_TURN;
        end
        else if (f1_req_reg.dx < 16'sd0)
        begin
            vec_next.z = (f1_req_reg.dy > 16'sd0) ? HALF_TURN : -HALF_TURN;
            vec_next.x = (-dx_ext) <<< 8;
            vec_next.y = (-dy_ext) <<< 8;
        end
    end

    // Annulus test
    assign d2  = sq_x_reg + sq_y_reg;
    assign hit = !f2_req_reg.req_type && !f2_req_reg.is_self
                 && (d2 > min_radius_sq) && (d2 < max_radius_sq);

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_ctl_reg   <= '0;
        end
        else if (en)
        begin
            f1_valid_reg        <= accept;
            f2_valid_reg        <= f1_valid_reg;
            f3_ctl_reg.valid    <= f2_valid_reg;
            f3_ctl_reg.is_read  <= f2_req_reg.req_type;
            f3_ctl_reg.is_hit   <= hit;
            f3_ctl_reg.read_bin <= f2_req_reg.read_bin;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_req_reg <= req_in;
            f2_req_reg <= f1_req_reg;
            sq_x_reg   <= $unsigned(sq_x);
            sq_y_reg   <= $unsigned(sq_y);
            f2_vec_reg <= vec_next;
            f3_vec_reg <= f2_vec_reg;
        end
    end

    assign ctl = f3_ctl_reg;
    assign vec = f3_vec_reg;

endmodule

[hdl/aah_cordic.sv]
module aah_cordic #(
    parameter int NUM_BINS = aah_pkg::NUM_BINS_DEF,
    parameter int AW       = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  aah_pkg::ctl_t   ctl_in,
    input  aah_pkg::vec_t   vec,
    output aah_pkg::ctl_t   ctl_out,
    output logic [AW-1:0]   sample_bin
);
    import aah_pkg::*;

    localparam int NBW = $clog2(NUM_BINS + 1);
    localparam int PW  = UW + NBW;

    logic signed [XW-1:0] x_reg [0:CORDIC_ITERS-1];
    logic signed [XW-1:0] y_reg [0:CORDIC_ITERS-1];
    logic signed [ZW-1:0] z_reg [0:CORDIC_ITERS-1];
    logic                 fx_reg [0:CORDIC_ITERS-1];
    ctl_t                 c_reg [0:CORDIC_ITERS-1];

    ctl_t          u_ctl_reg;
    logic [UW-1:0] u_reg;
    ctl_t          p_ctl_reg;
    logic [PW-1:0] prod_reg;

    logic signed [ZW-1:0] u_wide;
    logic [UW-1:0]        u_next;
    logic [NBW:0]         bin_hi;

    // One rotation per stage
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_stage
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic                 fx_in;
        ctl_t                 c_in;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] step;

        if (i == 0)
        begin : g_first
            assign x_in  = vec.x;
            assign y_in  = vec.y;
            assign z_in  = vec.z;
            assign fx_in = vec.fixed;
            assign c_in  = ctl_in;
        end
        else
        begin : g_next
            assign x_in  = x_reg[i-1];
            assign y_in  = y_reg[i-1];
            assign z_in  = z_reg[i-1];
            assign fx_in = fx_reg[i-1];
            assign c_in  = c_reg[i-1];
        end

        assign xs   = x_in >>> i;
        assign ys   = y_in >>> i;
        assign step = ZW'(atan_turn(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_reg[i] <= '0;
            end
            else if (en)
            begin
                c_reg[i] <= c_in;
            end
        end

        // Rotate toward the x axis; hold pinned angles
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fx_reg[i] <= fx_in;
                if (y_in > 0)
                begin
                    x_reg[i] <= x_in + ys;
                    y_reg[i] <= y_in - xs;
                    z_reg[i] <= fx_in ? z_in : z_in + step;
                end
                else
                begin
                    x_reg[i] <= x_in - ys;
                    y_reg[i] <= y_in + xs;
                    z_reg[i] <= fx_in ? z_in : z_in - step;
                end
            end
        end
    end

    // Shift angle to 0 .. full turn and clamp
    assign u_wide = z_reg[CORDIC_ITERS-1] + HALF_TURN;

    always_comb
    begin
        if (u_wide < 0)
        begin
            u_next = '0;
        end
        else if (u_wide > FULL_TURN)
        begin
            u_next = UW'(FULL_TURN);
        end
        else
        begin
            u_next = UW'(u_wide);
        end
    end

    // Scale to bins: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_ctl_reg <= '0;
            p_ctl_reg <= '0;
        end
        else if (en)
        begin
            u_ctl_reg <= c_reg[CORDIC_ITERS-1];
            p_ctl_reg <= u_ctl_reg;
        end
    end

    // Scale to bins: datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            prod_reg <= PW'(u_reg) * PW'(NUM_BINS);
        end
    end

    // Fold an angle of exactly pi into the last bin
    assign bin_hi     = prod_reg[PW-1:32];
    assign sample_bin = (bin_hi >= (NBW + 1)'(NUM_BINS)) ? AW'(NUM_BINS - 1) : AW'(bin_hi);
    assign ctl_out    = p_ctl_reg;

endmodule

[hdl/aah_hist.sv]
module aah_hist #(
    parameter int NUM_BINS = aah_pkg::NUM_BINS_DEF,
    parameter int AW       = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aah_pkg::ctl_t        ctl_in,
    input  logic [AW-1:0]        sample_bin,
    aah_stream_if.source         rsp,
    output aah_pkg::hist_stat_t  stat
);
    import aah_pkg::*;

    logic [31:0] mem [0:NUM_BINS-1];

    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    ctl_t          b_ctl_reg;
    logic [AW-1:0] b_addr_reg;
    logic          b_rb_ok_reg;
    logic [31:0]   rd_data_reg;

    logic          lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [31:0]   lw_data_reg;

    logic          out_valid_reg;
    rsp_t          out_data_reg;

    logic          adv;
    logic          rb_ok;
    logic [AW-1:0] addr_a;
    logic [31:0]   cur;
    logic [31:0]   inc;
    logic          do_write;
    rsp_t          out_next;

    // Pipeline moves whenever the output register can take a transfer
    assign adv = !out_valid_reg || rsp.ready;

    // Read address: requested bin or the sample's bin
    assign rb_ok  = 32'(ctl_in.read_bin) < 32'(NUM_BINS);
    assign addr_a = ctl_in.is_read ? (rb_ok ? AW'(ctl_in.read_bin) : '0) : sample_bin;

    // Forward the previous write, which the memory read missed
    assign cur      = (lw_valid_reg && (lw_addr_reg == b_addr_reg)) ? lw_data_reg : rd_data_reg;
    assign inc      = (&cur) ? cur : cur + 32'd1;
    assign do_write = adv && b_ctl_reg.valid && !b_ctl_reg.is_read && b_ctl_reg.is_hit;

    // Memory: clearing pass, then read-modify-write
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (do_write)
        begin
            mem[b_addr_reg] <= inc;
        end
        if (adv)
        begin
            rd_data_reg <= mem[addr_a];
        end
    end

    // Sweep every bin after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == AW'(NUM_BINS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // Build the result
    always_comb
    begin
        out_next = '0;
        if (b_ctl_reg.is_read)
        begin
            out_next.bin_index = b_ctl_reg.read_bin;
            out_next.bin_count = b_rb_ok_reg ? cur : '0;
        end
        else if (b_ctl_reg.is_hit)
        begin
            out_next.accepted  = 1'b1;
            out_next.bin_index = 5'(b_addr_reg);
            out_next.bin_count = inc;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg     <= '0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_ctl_reg     <= ctl_in;
            lw_valid_reg  <= b_ctl_reg.valid && !b_ctl_reg.is_read && b_ctl_reg.is_hit;
            out_valid_reg <= b_ctl_reg.valid;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_addr_reg   <= addr_a;
            b_rb_ok_reg  <= rb_ok;
            lw_addr_reg  <= b_addr_reg;
            lw_data_reg  <= inc;
            out_data_reg <= out_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.payload   = out_data_reg;
    assign stat.advance  = adv;
    assign stat.clearing = clearing_reg;

endmodule

[hdl/annulus_angle_histogram_top.sv]
// Throughput: one item per cycle while the response output is not stalled and no
// clearing pass runs; bin counts live in a one-port-write memory updated by
// read-modify-write, with the previous write forwarded to the next item.
// Reset: asynchronous, active low. Afterwards a clearing pass zeroes every bin
// with req.ready low; registers reset to 0 and 0x80000000.
module annulus_angle_histogram_top #(
    parameter int NUM_BINS = aah_pkg::NUM_BINS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    aah_stream_if.sink    req,
    aah_stream_if.source  rsp,
    aah_stream_if.sink    cfg
);
    import aah_pkg::*;

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [31:0]   min_radius_sq_reg;
    logic [31:0]   max_radius_sq_reg;
    hist_stat_t    stat;
    logic          accept;
    ctl_t          front_ctl;
    vec_t          front_vec;
    ctl_t          cordic_ctl;
    logic [AW-1:0] sample_bin;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_radius_sq_reg <= 32'h0000_0000;
            max_radius_sq_reg <= 32'h8000_0000;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                REG_MIN_RADIUS_SQ: min_radius_sq_reg <= cfg.payload.data;
                REG_MAX_RADIUS_SQ: max_radius_sq_reg <= cfg.payload.data;
                default:           ;
            endcase
        end
    end

    // Take an item when the pipeline moves and the histogram is cleared
    assign req.ready = stat.advance && !stat.clearing;
    assign accept    = req.valid && req.ready;

    aah_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (stat.advance),
        .accept        (accept),
        .req_in        (req.payload),
        .min_radius_sq (min_radius_sq_reg),
        .max_radius_sq (max_radius_sq_reg),
        .ctl           (front_ctl),
        .vec           (front_vec)
    );

    aah_cordic #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (stat.advance),
        .ctl_in     (front_ctl),
        .vec        (front_vec),
        .ctl_out    (cordic_ctl),
        .sample_bin (sample_bin)
    );

    aah_hist #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_hist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (cordic_ctl),
        .sample_bin (sample_bin),
        .rsp        (rsp),
        .stat       (stat)
    );

endmodule
